// ===== sv/pbid_pkg.sv =====
// ----------------------------------------------------------------------------
// pbid_pkg
// Shared types, constants and helper functions for the product basis index
// decoder: register codes, rotor block sizes and the rotor sub-index split.
// ----------------------------------------------------------------------------
`default_nettype none

package pbid_pkg;

   // Configuration register codes
   typedef enum logic [1:0] {
      CSR_MODE3_COUNT     = 2'd0,
      CSR_MODE5_COUNT     = 2'd1,
      CSR_FIRST_ROT_JMAX  = 2'd2,
      CSR_SECOND_ROT_JMAX = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;   // widest register
   localparam int CFG_CNT_W   = 11;   // mode count register width
   localparam int JMAX_W      = 3;    // rotor jmax register width
   localparam int MAX_J       = 7;    // largest rotor j
   localparam int J_W         = 3;    // rotor j output width
   localparam int M_W         = 4;    // rotor m output width, signed
   localparam int ROT_SUB_W   = 6;    // one rotor sub-index, below 64
   localparam int BLOCK_W     = 7;    // one rotor block size, up to 64
   localparam int ROT_PROD_W  = 13;   // product of both block sizes, up to 4096
   localparam int ROT_IDX_W   = 12;   // combined rotor index, below 4096

   typedef struct packed {
      logic [J_W-1:0]        j;
      logic signed [M_W-1:0] m;
   } rotor_qn_type;

   // (jmax + 1)^2
   function automatic logic [BLOCK_W-1:0] block_size(input logic [JMAX_W-1:0] jmax);
      logic [3:0] n;
      logic [7:0] sq;
      n  = {1'b0, jmax} + 4'd1;
      sq = {4'b0, n} * {4'b0, n};
      return sq[BLOCK_W-1:0];
   endfunction

   // j = floor(sqrt(r)) capped at MAX_J, m = r - j*j - j
   function automatic rotor_qn_type split_rotor(input logic [ROT_SUB_W-1:0] r);
      rotor_qn_type qn;
      int           jv;
      int           mv;
      jv = 0;
      for (int k = 1; k <= MAX_J; k++) begin
         if (k * k <= int'(r)) begin
            jv = k;
         end
      end
      mv   = int'(r) - jv * jv - jv;
      qn.j = J_W'(jv);
      qn.m = M_W'(mv);
      return qn;
   endfunction

endpackage

`default_nettype wire

// ===== sv/pbid_div_pipe.sv =====
// ----------------------------------------------------------------------------
// pbid_div_pipe
// Pipelined restoring divider: one quotient bit per register stage. The user
// must change the quasi-static divisor only while the pipe is empty; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module pbid_div_pipe
   import pbid_pkg::*;
#(
   parameter int DVD_W = 24,
   parameter int DVS_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [DVD_W-1:0] in_dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             out_valid,
   output logic [DVD_W-1:0] out_quotient,
   output logic [DVS_W-1:0] out_remainder
);

   logic             valid_ff [DVD_W];
   logic [DVS_W-1:0] rem_ff   [DVD_W];
   logic [DVS_W-1:0] rem_in   [DVD_W];
   logic [DVD_W-1:0] work_ff  [DVD_W];
   logic [DVD_W-1:0] work_in  [DVD_W];

   logic [DVS_W-1:0] prev_rem;
   logic [DVD_W-1:0] prev_work;
   logic [DVS_W:0]   trial;
   logic             qbit;

   // Per stage: shift in next dividend bit, trial subtract, shift out quotient bit
   always_comb begin
      for (int s = 0; s < DVD_W; s++) begin
         if (s == 0) begin
            prev_rem  = '0;
            prev_work = in_dividend;
         end else begin
            prev_rem  = rem_ff[s-1];
            prev_work = work_ff[s-1];
         end
         trial = {prev_rem, prev_work[DVD_W-1]};
         if (trial >= {1'b0, divisor}) begin
            rem_in[s] = DVS_W'(trial - {1'b0, divisor});
            qbit      = 1'b1;
         end else begin
            rem_in[s] = trial[DVS_W-1:0];
            qbit      = 1'b0;
         end
         work_in[s] = {prev_work[DVD_W-2:0], qbit};
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DVD_W; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < DVD_W; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      for (int s = 0; s < DVD_W; s++) begin
         rem_ff[s]  <= rem_in[s];
         work_ff[s] <= work_in[s];
      end
   end

   assign out_valid     = valid_ff[DVD_W-1];
   assign out_quotient  = work_ff[DVD_W-1];
   assign out_remainder = rem_ff[DVD_W-1];

endmodule

`default_nettype wire

// ===== sv/pbid_delay_line.sv =====
// ----------------------------------------------------------------------------
// pbid_delay_line
// Fixed-depth register delay that keeps side data aligned with the divider
// pipes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbid_delay_line
   import pbid_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // Shift line
   always_ff @(posedge clock) begin
      tap_ff[0] <= in_data;
      for (int s = 1; s < DEPTH; s++) begin
         tap_ff[s] <= tap_ff[s-1];
      end
   end

   assign out_data = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== sv/product_basis_index_decoder_top.sv =====
// Pipeline: three INDEX_BITS-stage and one 12-stage bit-per-stage divider pipes
//   plus input and output registers lie between the edge that accepts an item
//   and the rise of rsp_strobe.
// Throughput: one item per cycle; busy is always low and results never stall.
// Reset: synchronous, clears all valid bits and returns the configuration
//   registers to mode counts of 1 and rotor jmax of 0.
// ----------------------------------------------------------------------------
// product_basis_index_decoder_top
// Splits a flat basis index into three vibrational levels and two rotor
// (j, m) pairs by a chain of pipelined mixed-radix divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module product_basis_index_decoder_top
   import pbid_pkg::*;
#(
   parameter int INDEX_BITS = 24,
   parameter int COUNT_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   // request
   input  logic                    start,
   output logic                    busy,
   input  logic [INDEX_BITS-1:0]   req_flat_index,
   // configuration
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   // response
   output logic                    rsp_strobe,
   output logic [INDEX_BITS-1:0]   rsp_vib1_level,
   output logic [COUNT_BITS-1:0]   rsp_vib3_level,
   output logic [COUNT_BITS-1:0]   rsp_vib5_level,
   output logic [J_W-1:0]          rsp_rot1_j,
   output logic signed [M_W-1:0]   rsp_rot1_m,
   output logic [J_W-1:0]          rsp_rot2_j,
   output logic signed [M_W-1:0]   rsp_rot2_m
);

   localparam int CAP_W = 17;
   localparam logic [CAP_W-1:0] COUNT_CAP = CAP_W'(1) << COUNT_BITS;

   // Zero count reads as 1, counts above the level range saturate
   function automatic logic [CFG_CNT_W-1:0] eff_count(input logic [CFG_CNT_W-1:0] c);
      logic [CAP_W-1:0] wide;
      wide = CAP_W'(c);
      if (c == '0) begin
         return CFG_CNT_W'(1);
      end else if (wide > COUNT_CAP) begin
         return CFG_CNT_W'(COUNT_CAP);
      end else begin
         return c;
      end
   endfunction

   // Configuration registers
   logic [CFG_CNT_W-1:0] mode3_count_ff;
   logic [CFG_CNT_W-1:0] mode5_count_ff;
   logic [JMAX_W-1:0]    first_rot_jmax_ff;
   logic [JMAX_W-1:0]    second_rot_jmax_ff;

   // Derived divisors
   logic [CFG_CNT_W-1:0]  n3_ff;
   logic [CFG_CNT_W-1:0]  n5_ff;
   logic [BLOCK_W-1:0]    r2_ff;
   logic [ROT_PROD_W-1:0] nrot_ff;
   logic [BLOCK_W-1:0]    r1_blk;
   logic [BLOCK_W-1:0]    r2_blk;
   logic [2*BLOCK_W-1:0]  nrot_wide;

   // Input register
   logic                  req_valid_ff;
   logic [INDEX_BITS-1:0] flat_index_ff;

   // Divider chain
   logic                  d0_valid;
   logic [INDEX_BITS-1:0] d0_quot;
   logic [ROT_PROD_W-1:0] d0_rem;
   logic                  d1_valid;
   logic [INDEX_BITS-1:0] d1_quot;
   logic [CFG_CNT_W-1:0]  d1_rem;
   logic                  d2_valid;
   logic [INDEX_BITS-1:0] d2_quot;
   logic [CFG_CNT_W-1:0]  d2_rem;
   logic                  d3_valid;
   logic [ROT_IDX_W-1:0]  d3_quot;
   logic [BLOCK_W-1:0]    d3_rem;
   logic [ROT_IDX_W-1:0]  rot_idx_dly;
   logic [CFG_CNT_W-1:0]  v5_dly;
   logic [INDEX_BITS-1:0] v1_dly;
   logic [CFG_CNT_W-1:0]  v3_dly;

   rotor_qn_type          rot1_qn;
   rotor_qn_type          rot2_qn;

   // Output register
   logic                  rsp_strobe_ff;
   logic [INDEX_BITS-1:0] vib1_ff;
   logic [COUNT_BITS-1:0] vib3_ff;
   logic [COUNT_BITS-1:0] vib5_ff;
   rotor_qn_type          rot1_ff;
   rotor_qn_type          rot2_ff;

   assign busy = 1'b0;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode3_count_ff     <= CFG_CNT_W'(1);
         mode5_count_ff     <= CFG_CNT_W'(1);
         first_rot_jmax_ff  <= '0;
         second_rot_jmax_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE3_COUNT:     mode3_count_ff     <= csr_wdata;
            CSR_MODE5_COUNT:     mode5_count_ff     <= csr_wdata;
            CSR_FIRST_ROT_JMAX:  first_rot_jmax_ff  <= csr_wdata[JMAX_W-1:0];
            CSR_SECOND_ROT_JMAX: second_rot_jmax_ff <= csr_wdata[JMAX_W-1:0];
            default: ;
         endcase
      end
   end

   // Radices, registered in the cycle after the configuration changes
   assign r1_blk    = block_size(first_rot_jmax_ff);
   assign r2_blk    = block_size(second_rot_jmax_ff);
   assign nrot_wide = {{BLOCK_W{1'b0}}, r1_blk} * {{BLOCK_W{1'b0}}, r2_blk};

   always_ff @(posedge clock) begin
      if (reset) begin
         n3_ff   <= CFG_CNT_W'(1);
         n5_ff   <= CFG_CNT_W'(1);
         r2_ff   <= BLOCK_W'(1);
         nrot_ff <= ROT_PROD_W'(1);
      end else begin
         n3_ff   <= eff_count(mode3_count_ff);
         n5_ff   <= eff_count(mode5_count_ff);
         r2_ff   <= r2_blk;
         nrot_ff <= nrot_wide[ROT_PROD_W-1:0];
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      flat_index_ff <= req_flat_index;
   end

   // index / (R1*R2): quotient carries the vibrational part
   pbid_div_pipe #(.DVD_W(INDEX_BITS), .DVS_W(ROT_PROD_W)) u_div_rot (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid_ff),
      .in_dividend   (flat_index_ff),
      .divisor       (nrot_ff),
      .out_valid     (d0_valid),
      .out_quotient  (d0_quot),
      .out_remainder (d0_rem)
   );

   // quotient / n5 gives vib5 level
   pbid_div_pipe #(.DVD_W(INDEX_BITS), .DVS_W(CFG_CNT_W)) u_div_m5 (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d0_valid),
      .in_dividend   (d0_quot),
      .divisor       (n5_ff),
      .out_valid     (d1_valid),
      .out_quotient  (d1_quot),
      .out_remainder (d1_rem)
   );

   // quotient / n3 gives vib3 level and the leading vib1 level
   pbid_div_pipe #(.DVD_W(INDEX_BITS), .DVS_W(CFG_CNT_W)) u_div_m3 (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d1_valid),
      .in_dividend   (d1_quot),
      .divisor       (n3_ff),
      .out_valid     (d2_valid),
      .out_quotient  (d2_quot),
      .out_remainder (d2_rem)
   );

   // Rotor index waits for the two vibrational divisions
   pbid_delay_line #(.WIDTH(ROT_IDX_W), .DEPTH(2*INDEX_BITS)) u_dly_rot (
      .clock    (clock),
      .in_data  (d0_rem[ROT_IDX_W-1:0]),
      .out_data (rot_idx_dly)
   );

   // Rotor index / R2 splits the two rotor sub-indices
   pbid_div_pipe #(.DVD_W(ROT_IDX_W), .DVS_W(BLOCK_W)) u_div_r2 (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d2_valid),
      .in_dividend   (rot_idx_dly),
      .divisor       (r2_ff),
      .out_valid     (d3_valid),
      .out_quotient  (d3_quot),
      .out_remainder (d3_rem)
   );

   // Vibrational levels wait for the rotor division
   pbid_delay_line #(.WIDTH(CFG_CNT_W), .DEPTH(INDEX_BITS+ROT_IDX_W)) u_dly_v5 (
      .clock    (clock),
      .in_data  (d1_rem),
      .out_data (v5_dly)
   );

   pbid_delay_line #(.WIDTH(INDEX_BITS), .DEPTH(ROT_IDX_W)) u_dly_v1 (
      .clock    (clock),
      .in_data  (d2_quot),
      .out_data (v1_dly)
   );

   pbid_delay_line #(.WIDTH(CFG_CNT_W), .DEPTH(ROT_IDX_W)) u_dly_v3 (
      .clock    (clock),
      .in_data  (d2_rem),
      .out_data (v3_dly)
   );

   // Rotor sub-index to (j, m) by table
   assign rot1_qn = split_rotor(d3_quot[ROT_SUB_W-1:0]);
   assign rot2_qn = split_rotor(d3_rem[ROT_SUB_W-1:0]);

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      vib1_ff <= v1_dly;
      vib3_ff <= COUNT_BITS'(v3_dly);
      vib5_ff <= COUNT_BITS'(v5_dly);
      rot1_ff <= rot1_qn;
      rot2_ff <= rot2_qn;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_vib1_level = vib1_ff;
   assign rsp_vib3_level = vib3_ff;
   assign rsp_vib5_level = vib5_ff;
   assign rsp_rot1_j     = rot1_ff.j;
   assign rsp_rot1_m     = rot1_ff.m;
   assign rsp_rot2_j     = rot2_ff.j;
   assign rsp_rot2_m     = rot2_ff.m;

`ifndef SYNTHESIS
   // Vibrational levels stay below their effective mode counts
   a_vib3_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (CAP_W'(rsp_vib3_level) < CAP_W'(n3_ff)))
      else $error("vib3 level not below mode3 count");

   a_vib5_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (CAP_W'(rsp_vib5_level) < CAP_W'(n5_ff)))
      else $error("vib5 level not below mode5 count");

   // Rotor 2 j within configured jmax, rotor 1 m within -j..j
   a_rot2_j_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_rot2_j <= second_rot_jmax_ff))
      else $error("rotor 2 j above jmax");

   a_rot1_m_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (($signed({1'b0, rsp_rot1_j}) >= rsp_rot1_m) &&
                      (rsp_rot1_m >= -$signed({1'b0, rsp_rot1_j}))))
      else $error("rotor 1 m outside -j..j");
`endif

endmodule

`default_nettype wire

// ===== test/tb_product_basis_index_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_product_basis_index_decoder_top
// Self-checking bench for the basis index decoder. A driver feeds flat
// indices from a queue with random idle gaps. A monitor predicts the seven
// quantum numbers of every accepted item from its own copy of the radix
// registers, then checks each strobed result against the oldest prediction.
// Directed corner cases run first, then randomly configured phases with
// row scans, radix boundaries and free-running indices.
// ----------------------------------------------------------------------------

module tb_product_basis_index_decoder_top;
   import pbid_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int INDEX_BITS = 24;
   localparam int COUNT_BITS = 10;
   localparam int HALF_PERIOD = 5;
   localparam longint unsigned INDEX_SPAN = 64'd1 << INDEX_BITS;
   localparam int ITEMS_PER_PHASE = 128;
   localparam int RANDOM_PHASES = 8;
   localparam int TAIL_CYCLES = 120;
   localparam int STALL_LIMIT = 2000;

   // Expected quantum numbers of one decoded index
   typedef struct packed {
      logic [INDEX_BITS-1:0] vib1;
      logic [COUNT_BITS-1:0] vib3;
      logic [COUNT_BITS-1:0] vib5;
      rotor_qn_type          rot1;
      rotor_qn_type          rot2;
   } basis_levels_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [INDEX_BITS-1:0]  req_flat_index = '0;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MODE3_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   rsp_strobe;
   logic [INDEX_BITS-1:0]  rsp_vib1_level;
   logic [COUNT_BITS-1:0]  rsp_vib3_level;
   logic [COUNT_BITS-1:0]  rsp_vib5_level;
   logic [J_W-1:0]         rsp_rot1_j;
   logic signed [M_W-1:0]  rsp_rot1_m;
   logic [J_W-1:0]         rsp_rot2_j;
   logic signed [M_W-1:0]  rsp_rot2_m;

   // Shadow of the radix registers, as written
   logic [CFG_CNT_W-1:0] cfg_mode3 = 1;
   logic [CFG_CNT_W-1:0] cfg_mode5 = 1;
   logic [JMAX_W-1:0]    cfg_jmax1 = 0;
   logic [JMAX_W-1:0]    cfg_jmax2 = 0;

   logic [INDEX_BITS-1:0] pending_indices[$];
   basis_levels_type      expected_levels[$];
   basis_levels_type      oldest_levels;
   logic                  item_taken = 1'b0;
   bit                    steady_feed = 1'b0;
   int unsigned           gap_left = 0;
   int unsigned           quiet_cycles = 0;
   int unsigned           mismatch_count = 0;

   product_basis_index_decoder_top #(
      .INDEX_BITS(INDEX_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_flat_index(req_flat_index),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe),
      .rsp_vib1_level(rsp_vib1_level),
      .rsp_vib3_level(rsp_vib3_level),
      .rsp_vib5_level(rsp_vib5_level),
      .rsp_rot1_j(rsp_rot1_j),
      .rsp_rot1_m(rsp_rot1_m),
      .rsp_rot2_j(rsp_rot2_j),
      .rsp_rot2_m(rsp_rot2_m)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Mode count as used: zero acts as one, large counts clip to 2^COUNT_BITS
   function automatic longint unsigned eff_levels(input logic [CFG_CNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > (1 << COUNT_BITS)) return 64'd1 << COUNT_BITS;
      return count;
   endfunction

   // Rotor block size (jmax + 1)^2, jmax clipped to MAX_J
   function automatic longint unsigned rotor_block(input logic [JMAX_W-1:0] jmax);
      longint unsigned n;
      n = (jmax > MAX_J) ? MAX_J + 1 : jmax + 1;
      return n * n;
   endfunction

   // Rotor sub-index to (j, m): strip odd-sized j shells of 2*j+1 projections
   function automatic rotor_qn_type peel_rotor(input longint unsigned sub);
      rotor_qn_type qn;
      int           j;
      int           m;
      j = 0;
      while (j < MAX_J && longint'((j + 1) * (j + 1)) <= sub) j++;
      m    = int'(sub) - j * j - j;
      qn.j = J_W'(j);
      qn.m = M_W'(m);
      return qn;
   endfunction

   // Mixed-radix split of one flat index under the current shadow registers
   function automatic basis_levels_type decode_basis_index(input logic [INDEX_BITS-1:0] flat);
      basis_levels_type lv;
      longint unsigned  n3, n5, b2, nrot, rest;
      n3   = eff_levels(cfg_mode3);
      n5   = eff_levels(cfg_mode5);
      b2   = rotor_block(cfg_jmax2);
      nrot = rotor_block(cfg_jmax1) * b2;
      rest = flat;
      lv.vib1 = INDEX_BITS'(rest / (n3 * n5 * nrot));
      rest    = rest % (n3 * n5 * nrot);
      lv.vib3 = COUNT_BITS'(rest / (n5 * nrot));
      rest    = rest % (n5 * nrot);
      lv.vib5 = COUNT_BITS'(rest / nrot);
      rest    = rest % nrot;
      lv.rot1 = peel_rotor(rest / b2);
      lv.rot2 = peel_rotor(rest % b2);
      return lv;
   endfunction

   // Idle gap after an item: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Random index: free 24-bit, within a few basis spans, or at a radix edge
   function automatic logic [INDEX_BITS-1:0] pick_index();
      longint unsigned nrot, n5r, full, unit, span, pick;
      int unsigned     sel;
      nrot = rotor_block(cfg_jmax1) * rotor_block(cfg_jmax2);
      n5r  = eff_levels(cfg_mode5) * nrot;
      full = eff_levels(cfg_mode3) * n5r;
      sel  = $urandom_range(0, 9);
      if (sel < 3) return INDEX_BITS'($urandom());
      if (sel < 7) begin
         span = full * $urandom_range(1, 6);
         if (span > INDEX_SPAN) span = INDEX_SPAN;
         return INDEX_BITS'({$urandom(), $urandom()} % span);
      end
      case ($urandom_range(0, 3))
         0: unit = rotor_block(cfg_jmax2);
         1: unit = nrot;
         2: unit = n5r;
         default: unit = full;
      endcase
      pick = unit * $urandom_range(1, 20) - $urandom_range(0, 1);
      if (pick >= INDEX_SPAN) return INDEX_BITS'($urandom());
      return INDEX_BITS'(pick);
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // One register write on the csr port, shadow updated alongside
   task automatic put_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MODE3_COUNT:     cfg_mode3 = value;
         CSR_MODE5_COUNT:     cfg_mode5 = value;
         CSR_FIRST_ROT_JMAX:  cfg_jmax1 = value[JMAX_W-1:0];
         CSR_SECOND_ROT_JMAX: cfg_jmax2 = value[JMAX_W-1:0];
      endcase
   endtask

   task automatic set_radices(input logic [CSR_DATA_W-1:0] m3, input logic [CSR_DATA_W-1:0] m5,
                              input logic [JMAX_W-1:0] j1, input logic [JMAX_W-1:0] j2);
      put_csr(CSR_MODE3_COUNT, m3);
      put_csr(CSR_MODE5_COUNT, m5);
      put_csr(CSR_FIRST_ROT_JMAX, CSR_DATA_W'(j1));
      put_csr(CSR_SECOND_ROT_JMAX, CSR_DATA_W'(j2));
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      #1;
   endtask

   // Block until every queued item is accepted and its result has come back
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_indices.size() != 0 || start || expected_levels.size() != 0);
   endtask

   // Random mode count: small mostly, with zero, exact cap and above cap
   function automatic logic [CSR_DATA_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return CSR_DATA_W'(0);
         1:       return CSR_DATA_W'(1024);
         2:       return CSR_DATA_W'($urandom_range(1025, 2047));
         3, 4, 5: return CSR_DATA_W'($urandom_range(1, 4));
         6, 7, 8: return CSR_DATA_W'($urandom_range(2, 40));
         default: return CSR_DATA_W'($urandom_range(1, 2047));
      endcase
   endfunction

   // Driver: present the next index at the falling edge, hold until taken
   always @(negedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else if (!start || item_taken) begin
         if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_indices.size() != 0) begin
            req_flat_index <= pending_indices.pop_front();
            start          <= 1'b1;
            gap_left       <= steady_feed ? 0 : pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check strobed results, predict accepted items, track stalls
   always @(posedge clock) begin
      if (reset) begin
         item_taken   <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_levels.size() == 0) begin
               $error("result strobed with no item outstanding");
               mismatch_count++;
            end else begin
               oldest_levels = expected_levels.pop_front();
               check_field("vib1_level", oldest_levels.vib1, rsp_vib1_level);
               check_field("vib3_level", oldest_levels.vib3, rsp_vib3_level);
               check_field("vib5_level", oldest_levels.vib5, rsp_vib5_level);
               check_field("rot1_j", oldest_levels.rot1.j, rsp_rot1_j);
               check_field("rot1_m", $unsigned(oldest_levels.rot1.m),
                           rsp_rot1_m[M_W-1:0]);
               check_field("rot2_j", oldest_levels.rot2.j, rsp_rot2_j);
               check_field("rot2_m", $unsigned(oldest_levels.rot2.m),
                           rsp_rot2_m[M_W-1:0]);
            end
         end
         if (start && !busy) expected_levels.push_back(decode_basis_index(req_flat_index));
         item_taken   <= start && !busy;
         quiet_cycles <= (rsp_strobe || (start && !busy)) ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog on cycles with no handshake at all
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("** product_basis_index_decoder_top: FAILED **");
      $finish;
   end

   initial begin
      logic [INDEX_BITS-1:0] base;
      int unsigned           queued;
      int unsigned           run_len;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // Reset radices: every divisor is one, the index passes straight through
      pending_indices.push_back(24'h000000);
      pending_indices.push_back(24'hFFFFFF);
      pending_indices.push_back(24'h5A5A5A);
      wait_drained();

      // Zero count acts as one, count above the cap clips, both rotors full
      set_radices(0, 2047, 7, 7);
      pending_indices.push_back(24'd0);
      pending_indices.push_back(24'd49);
      pending_indices.push_back(24'd63);
      pending_indices.push_back(24'd64);
      pending_indices.push_back(24'd4095);
      pending_indices.push_back(24'd4096);
      pending_indices.push_back(24'h3FFFFF);
      pending_indices.push_back(24'h400000);
      pending_indices.push_back(24'hFFFFFF);
      pending_indices.push_back(24'h2AAAAA);
      wait_drained();

      // Counts at the cap, no rotor freedom: top levels of both modes
      set_radices(1024, 1024, 0, 0);
      pending_indices.push_back(24'h000000);
      pending_indices.push_back(24'h0003FF);
      pending_indices.push_back(24'h000400);
      pending_indices.push_back(24'h0FFFFF);
      pending_indices.push_back(24'h100000);
      pending_indices.push_back(24'hFFFFFF);
      wait_drained();

      // Uneven radices with only the first rotor active
      set_radices(3, 5, 7, 0);
      pending_indices.push_back(24'd63);
      pending_indices.push_back(24'd64);
      pending_indices.push_back(24'd959);
      pending_indices.push_back(24'd960);
      pending_indices.push_back(24'h123456);
      wait_drained();

      // Random phases: row scans, in-span indices, boundary hits and free indices
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_radices(pick_count(), pick_count(),
                     JMAX_W'($urandom_range(0, 7)), JMAX_W'($urandom_range(0, 7)));
         steady_feed = (phase == 3);
         queued      = 0;
         while (queued < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 3) begin
               base    = pick_index();
               run_len = $urandom_range(4, 16);
               for (int k = 0; k < run_len; k++)
                  pending_indices.push_back(base + INDEX_BITS'(k));
               queued += run_len;
            end else begin
               pending_indices.push_back(pick_index());
               queued++;
            end
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_levels.size() == 0)
         $display("** product_basis_index_decoder_top: PASSED **");
      else
         $display("** product_basis_index_decoder_top: FAILED **");
      $finish;
   end

endmodule
